/* src/bftm_pkg.sv */
// bftm_pkg: shared types, codes and the command decoder of the tape machine
// used by bftm_ctrl, bftm_dpath and bf_tape_machine_core; no dependencies

package bftm_pkg;

   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 3;
   localparam int PC_OUT_W = 13;
   localparam int DP_OUT_W = 12;

   localparam logic [BYTE_W-1:0] CHAR_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CHAR_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_IN    = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_STEP    = 2'd1,
      OP_RESTART = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [CODE_W-1:0] {
      CMD_RIGHT = 3'd0,
      CMD_LEFT  = 3'd1,
      CMD_INC   = 3'd2,
      CMD_DEC   = 3'd3,
      CMD_OUT   = 3'd4,
      CMD_IN    = 3'd5,
      CMD_OPEN  = 3'd6,
      CMD_CLOSE = 3'd7
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DONE      = 3'd1,
      ST_UNMATCHED = 3'd2,
      ST_END_MEM   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [BYTE_W-1:0]   program_char;
      logic [BYTE_W-1:0]   in_byte;
      logic                in_byte_valid;
   } bftm_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                out_valid;
      status_type          status;
      logic [PC_OUT_W-1:0] program_counter;
      logic [DP_OUT_W-1:0] data_pointer;
   } bftm_rsp_type;

   typedef struct packed {
      logic load_req;
      logic dispatch;
      logic exec;
      logic scan_step;
      logic scan_check;
      logic wipe;
      logic publish;
   } bftm_cmd_type;

   typedef struct packed {
      op_type op;
      logic   step_blocked;
      logic   jump;
      logic   scan_fail;
      logic   found;
      logic   wipe_last;
      logic   slot_free;
   } bftm_flags_type;

   typedef struct packed {
      logic         hit;
      cmd_code_type code;
   } encoded_type;

   function automatic encoded_type encode_char(input logic [BYTE_W-1:0] ch);
      encoded_type enc;
      enc.hit  = 1'b1;
      enc.code = CMD_RIGHT;
      case (ch)
         CHAR_RIGHT: enc.code = CMD_RIGHT;
         CHAR_LEFT:  enc.code = CMD_LEFT;
         CHAR_INC:   enc.code = CMD_INC;
         CHAR_DEC:   enc.code = CMD_DEC;
         CHAR_OUT:   enc.code = CMD_OUT;
         CHAR_IN:    enc.code = CMD_IN;
         CHAR_OPEN:  enc.code = CMD_OPEN;
         CHAR_CLOSE: enc.code = CMD_CLOSE;
         default:    enc.hit  = 1'b0;
      endcase
      return enc;
   endfunction

endpackage

/* src/bftm_ram.sv */
// bftm_ram: generic single write port, single read port ram with registered read
// no dependencies

module bftm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bftm_ctrl.sv */
// bftm_ctrl: sequencing state machine of the tape machine
// depends on bftm_pkg

module bftm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bftm_pkg::bftm_flags_type flags,
   output bftm_pkg::bftm_cmd_type   cmd
);
   import bftm_pkg::*;

   typedef enum logic [2:0] {
      S_WIPE_INIT,
      S_IDLE,
      S_DISPATCH,
      S_EXEC,
      S_SCAN_STEP,
      S_SCAN_CHECK,
      S_WIPE,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_WIPE_INIT: begin
            cmd.wipe = 1'b1;
            if (flags.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            case (flags.op)
               OP_STEP:    state_in = flags.step_blocked ? S_RESP : S_EXEC;
               OP_RESTART: state_in = S_WIPE;
               default:    state_in = S_RESP;
            endcase
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = flags.jump ? S_SCAN_STEP : S_RESP;
         end
         S_SCAN_STEP: begin
            cmd.scan_step = 1'b1;
            state_in      = flags.scan_fail ? S_RESP : S_SCAN_CHECK;
         end
         S_SCAN_CHECK: begin
            cmd.scan_check = 1'b1;
            state_in       = flags.found ? S_RESP : S_SCAN_STEP;
         end
         S_WIPE: begin
            cmd.wipe = 1'b1;
            if (flags.wipe_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (flags.slot_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* src/bftm_dpath.sv */
// bftm_dpath: machine registers, program store, tape and result register
// depends on bftm_pkg and bftm_ram

module bftm_dpath #(
   parameter int PROGRAM_DEPTH = 4096,
   parameter int TAPE_DEPTH    = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bftm_pkg::bftm_cmd_type   cmd,
   output bftm_pkg::bftm_flags_type flags,
   input  bftm_pkg::bftm_req_type   req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bftm_pkg::bftm_rsp_type   rsp_data
);
   import bftm_pkg::*;

   localparam int PA = $clog2(PROGRAM_DEPTH);
   localparam int PW = $clog2(PROGRAM_DEPTH + 1);
   localparam int TA = $clog2(TAPE_DEPTH);
   localparam int BW = PW + 1;
   localparam logic [PW-1:0] PROG_FULL = PW'(PROGRAM_DEPTH);
   localparam logic [PW-1:0] PW_ONE    = PW'(1);
   localparam logic [TA-1:0] TAPE_LAST = TA'(TAPE_DEPTH - 1);
   localparam logic [TA-1:0] TA_ONE    = TA'(1);
   localparam logic [BW-1:0] BW_ONE    = BW'(1);

   bftm_req_type        req_ff, req_in;
   logic [PW-1:0]       pc_ff, pc_in;
   logic [TA-1:0]       cell_ff, cell_in;
   logic [PW-1:0]       len_ff, len_in;
   logic [BW-1:0]       bal_ff, bal_in;
   logic [TA-1:0]       clr_ff, clr_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       depth_ff, depth_in;
   logic                fwd_ff, fwd_in;
   logic [BYTE_W-1:0]   ob_ff, ob_in;
   logic                ov_ff, ov_in;
   status_type          st_ff, st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bftm_rsp_type        rsp_data_ff, rsp_data_in;

   logic                prog_we;
   logic [PA-1:0]       prog_waddr;
   logic [CODE_W-1:0]   prog_wdata;
   logic [PA-1:0]       prog_raddr;
   logic [CODE_W-1:0]   prog_rdata;
   logic                tape_we;
   logic [TA-1:0]       tape_waddr;
   logic [BYTE_W-1:0]   tape_wdata;
   logic [BYTE_W-1:0]   tape_rdata;

   encoded_type         enc;
   cmd_code_type        code;
   cmd_code_type        same_br;
   cmd_code_type        other_br;
   logic                cell_zero;
   logic                bound_hit;
   logic                jump;
   logic                step_blocked;
   logic [PW-1:0]       pc_inc;
   logic [PW-1:0]       pos_inc;
   logic [PW-1:0]       scan_next;
   logic                scan_fail;
   logic                found;
   logic [31:0]         pc_ext;
   logic [31:0]         cell_ext;

   bftm_ram #(.WIDTH(CODE_W), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (prog_waddr),
      .wr_data (prog_wdata),
      .rd_addr (prog_raddr),
      .rd_data (prog_rdata)
   );

   bftm_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape_ram (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_addr (cell_ff),
      .rd_data (tape_rdata)
   );

   always_comb begin
      enc          = encode_char(req_ff.program_char);
      code         = cmd_code_type'(prog_rdata);
      cell_zero    = (tape_rdata == '0);
      pc_inc       = pc_ff + PW_ONE;
      pos_inc      = pos_ff + PW_ONE;
      bound_hit    = (code == CMD_RIGHT && cell_ff == TAPE_LAST) ||
                     (code == CMD_LEFT && cell_ff == '0);
      jump         = (code == CMD_OPEN && cell_zero) || (code == CMD_CLOSE && !cell_zero);
      step_blocked = (bal_ff != '0) || (pc_ff >= len_ff);
      scan_next    = fwd_ff ? pos_inc : (pos_ff - PW_ONE);
      scan_fail    = fwd_ff ? (pos_inc >= len_ff) : (pos_ff == '0);
      same_br      = fwd_ff ? CMD_OPEN : CMD_CLOSE;
      other_br     = fwd_ff ? CMD_CLOSE : CMD_OPEN;
      found        = (code == other_br) && (depth_ff == PW_ONE);
      pc_ext       = 32'(pc_ff);
      cell_ext     = 32'(cell_ff);
   end

   always_comb begin
      flags.op           = req_ff.operation;
      flags.step_blocked = step_blocked;
      flags.jump         = jump;
      flags.scan_fail    = scan_fail;
      flags.found        = found;
      flags.wipe_last    = (clr_ff == TAPE_LAST);
      flags.slot_free    = !rsp_valid_ff || rsp_ready;
   end

   assign prog_raddr = cmd.scan_step ? scan_next[PA-1:0] : pc_ff[PA-1:0];
   assign prog_waddr = len_ff[PA-1:0];
   assign prog_wdata = enc.code;

   always_comb begin
      req_in     = req_ff;
      pc_in      = pc_ff;
      cell_in    = cell_ff;
      len_in     = len_ff;
      bal_in     = bal_ff;
      clr_in     = clr_ff;
      pos_in     = pos_ff;
      depth_in   = depth_ff;
      fwd_in     = fwd_ff;
      ob_in      = ob_ff;
      ov_in      = ov_ff;
      st_in      = st_ff;
      prog_we    = 1'b0;
      tape_we    = 1'b0;
      tape_waddr = cell_ff;
      tape_wdata = '0;

      if (cmd.load_req) begin
         req_in = req_data;
         ob_in  = '0;
         ov_in  = 1'b0;
         st_in  = ST_OK;
      end

      if (cmd.dispatch) begin
         case (req_ff.operation)
            OP_APPEND: begin
               if (enc.hit) begin
                  if (len_ff == PROG_FULL) begin
                     st_in = ST_FULL;
                  end else begin
                     prog_we = 1'b1;
                     len_in  = len_ff + PW_ONE;
                     if (enc.code == CMD_OPEN) begin
                        bal_in = bal_ff + BW_ONE;
                     end else if (enc.code == CMD_CLOSE) begin
                        bal_in = bal_ff - BW_ONE;
                     end
                  end
               end
            end
            OP_STEP: begin
               if (bal_ff != '0) begin
                  st_in = ST_UNMATCHED;
               end else if (pc_ff >= len_ff) begin
                  st_in = ST_DONE;
               end
            end
            OP_RESTART: begin
               pc_in   = '0;
               cell_in = '0;
               clr_in  = '0;
            end
            default: begin
               len_in = '0;
               bal_in = '0;
               pc_in  = '0;
            end
         endcase
      end

      if (cmd.exec) begin
         if (bound_hit) begin
            st_in = ST_END_MEM;
         end else if (jump) begin
            pos_in   = pc_ff;
            depth_in = PW_ONE;
            fwd_in   = (code == CMD_OPEN);
         end else begin
            pc_in = pc_inc;
            st_in = (pc_inc >= len_ff) ? ST_DONE : ST_OK;
            case (code)
               CMD_RIGHT: cell_in = cell_ff + TA_ONE;
               CMD_LEFT:  cell_in = cell_ff - TA_ONE;
               CMD_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata + 8'd1;
               end
               CMD_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata - 8'd1;
               end
               CMD_OUT: begin
                  ob_in = tape_rdata;
                  ov_in = 1'b1;
               end
               CMD_IN: begin
                  tape_we    = req_ff.in_byte_valid;
                  tape_wdata = req_ff.in_byte;
               end
               default: begin
                  cell_in = cell_ff;
               end
            endcase
         end
      end

      if (cmd.scan_step) begin
         if (scan_fail) begin
            st_in = ST_UNMATCHED;
         end else begin
            pos_in = scan_next;
         end
      end

      if (cmd.scan_check) begin
         if (found) begin
            pc_in = pos_inc;
            st_in = (pos_inc >= len_ff) ? ST_DONE : ST_OK;
         end else if (code == same_br) begin
            depth_in = depth_ff + PW_ONE;
         end else if (code == other_br) begin
            depth_in = depth_ff - PW_ONE;
         end
      end

      if (cmd.wipe) begin
         tape_we    = 1'b1;
         tape_waddr = clr_ff;
         tape_wdata = '0;
         clr_in     = (clr_ff == TAPE_LAST) ? '0 : (clr_ff + TA_ONE);
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.publish) begin
         rsp_data_in.out_byte        = ob_ff;
         rsp_data_in.out_valid       = ov_ff;
         rsp_data_in.status          = st_ff;
         rsp_data_in.program_counter = pc_ext[PC_OUT_W-1:0];
         rsp_data_in.data_pointer    = cell_ext[DP_OUT_W-1:0];
      end
      rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         cell_ff      <= '0;
         len_ff       <= '0;
         bal_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cell_ff      <= cell_in;
         len_ff       <= len_in;
         bal_ff       <= bal_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pos_ff      <= pos_in;
      depth_ff    <= depth_in;
      fwd_ff      <= fwd_in;
      ob_ff       <= ob_in;
      ov_ff       <= ov_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/bf_tape_machine_core.sv */
// bf_tape_machine_core: tape machine top level over bftm_ctrl, bftm_dpath, bftm_ram, bftm_pkg
// path of a transaction: dispatch then result for append, clear and blocked steps; a plain step
// adds execute between them, and a taken bracket a scan over program entries (ended if unmatched);
// a restart wipes the tape between dispatch and result
// one transaction in flight; a new request is taken only after the previous result is published
// reset: synchronous; after reset the tape ram is wiped with req_ready low

module bf_tape_machine_core #(
   parameter int PROGRAM_DEPTH = 4096,
   parameter int TAPE_DEPTH    = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bftm_pkg::bftm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bftm_pkg::bftm_rsp_type rsp_data
);
   import bftm_pkg::*;

   bftm_cmd_type   cmd;
   bftm_flags_type flags;

   bftm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   bftm_dpath #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH),
      .TAPE_DEPTH    (TAPE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .flags     (flags),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.dispatch)
      else $error("accepted transaction not dispatched");

   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.wipe |-> !req_ready)
      else $error("request taken during tape wipe");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.publish))
      else $error("result raised without publish");

endmodule
